// ----- design/imu_frame_parser_top_macros.svh -----
// assertion macros for the imu frame parser checker
`ifndef IMU_FRAME_PARSER_TOP_MACROS_SVH
`define IMU_FRAME_PARSER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define IFP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// implication with the consequent checked in the following cycle
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- design/ifp_pkg.sv -----
// shared types and constants for the imu frame parser
`timescale 1ns / 1ps
`default_nettype none
package ifp_pkg;
   localparam int NumQ = 14;
   localparam logic [7:0] Preamble = 8'hFA;
   localparam logic [7:0] BusByte = 8'hFF;
   localparam logic [7:0] ExtLen = 8'hFF;
   localparam logic [15:0] GrpMask = 16'hF800;
   localparam logic [15:0] FmtMask = 16'h00F0;
   localparam logic [15:0] GrpTemp = 16'h0800;
   localparam logic [15:0] GrpCount = 16'h1000;
   localparam logic [15:0] GrpEuler = 16'h2000;
   localparam logic [15:0] GrpAccel = 16'h4000;
   localparam logic [15:0] GrpGyro = 16'h8000;
   localparam logic [15:0] GrpMag = 16'hC000;
   localparam logic [15:0] FmtF1 = 16'h0010;
   localparam logic [15:0] FmtF2 = 16'h0020;
   localparam logic [15:0] FmtF3 = 16'h0030;

   typedef enum logic [11:0] {
      ST_HUNT = 12'b000000000001,
      ST_BUS  = 12'b000000000010,
      ST_MID  = 12'b000000000100,
      ST_LEN  = 12'b000000001000,
      ST_EXTH = 12'b000000010000,
      ST_EXTL = 12'b000000100000,
      ST_SIDH = 12'b000001000000,
      ST_SIDL = 12'b000010000000,
      ST_SLEN = 12'b000100000000,
      ST_DATA = 12'b001000000000,
      ST_CHK  = 12'b010000000000,
      ST_EMIT = 12'b100000000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start_frame;   // bus byte seen: seed sum with the bus byte, clear length and pending mask
      logic add_sum;
      logic load_mid;
      logic load_len;
      logic load_exth;
      logic load_extl;
      logic dec_len;
      logic load_sidh;
      logic load_sidl;
      logic load_slen;
      logic take_data;
      logic check;         // checksum byte
      logic emit_step;     // one record word taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic len_zero;      // length being loaded is zero
      logic rem_last;      // payload ends with this byte
      logic slen_zero;
      logic sub_end;       // data byte closes the sub-packet
      logic sum_ok;        // sum including this byte is zero
      logic emit_last;
   } stat_type;
endpackage
`default_nettype wire

// ----- design/ifp_ctrl.sv -----
// frame sequencing state machine
`timescale 1ns / 1ps
`default_nettype none
module ifp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             byte_valid,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             out_free,
   input  wire ifp_pkg::stat_type stat,
   output ifp_pkg::cmd_type      cmd,
   output logic                  in_ready
);
   ifp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifp_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // checksum byte waits until the output register can take its result
   assign in_ready = (state_ff != ifp_pkg::ST_EMIT) &&
                     (state_ff != ifp_pkg::ST_CHK || out_free);

   always_comb begin
      logic go;
      go = byte_valid && in_ready;
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff) inside
         ifp_pkg::ST_HUNT: begin
            if (go && rx_byte == ifp_pkg::Preamble) state_in = ifp_pkg::ST_BUS;
         end
         ifp_pkg::ST_BUS: begin
            if (go) begin
               if (rx_byte == ifp_pkg::BusByte) begin
                  cmd.start_frame = 1'b1;
                  state_in = ifp_pkg::ST_MID;
               end else if (rx_byte != ifp_pkg::Preamble) begin
                  state_in = ifp_pkg::ST_HUNT;
               end
            end
         end
         ifp_pkg::ST_MID: begin
            if (go) begin
               cmd.add_sum = 1'b1;
               cmd.load_mid = 1'b1;
               state_in = ifp_pkg::ST_LEN;
            end
         end
         ifp_pkg::ST_LEN: begin
            if (go) begin
               cmd.add_sum = 1'b1;
               if (rx_byte == ifp_pkg::ExtLen) begin
                  state_in = ifp_pkg::ST_EXTH;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in = stat.len_zero ? ifp_pkg::ST_CHK : ifp_pkg::ST_SIDH;
               end
            end
         end
         ifp_pkg::ST_EXTH: begin
            if (go) begin
               cmd.add_sum = 1'b1;
               cmd.load_exth = 1'b1;
               state_in = ifp_pkg::ST_EXTL;
            end
         end
         ifp_pkg::ST_EXTL: begin
            if (go) begin
               cmd.add_sum = 1'b1;
               cmd.load_extl = 1'b1;
               state_in = stat.len_zero ? ifp_pkg::ST_CHK : ifp_pkg::ST_SIDH;
            end
         end
         ifp_pkg::ST_SIDH, ifp_pkg::ST_SIDL, ifp_pkg::ST_SLEN, ifp_pkg::ST_DATA: begin
            if (go) begin
               cmd.add_sum = 1'b1;
               cmd.dec_len = 1'b1;
               if (state_ff == ifp_pkg::ST_SIDH) begin
                  cmd.load_sidh = 1'b1;
                  state_in = ifp_pkg::ST_SIDL;
               end else if (state_ff == ifp_pkg::ST_SIDL) begin
                  cmd.load_sidl = 1'b1;
                  state_in = ifp_pkg::ST_SLEN;
               end else if (state_ff == ifp_pkg::ST_SLEN) begin
                  cmd.load_slen = 1'b1;
                  state_in = stat.slen_zero ? ifp_pkg::ST_SIDH : ifp_pkg::ST_DATA;
               end else begin
                  cmd.take_data = 1'b1;
                  if (stat.sub_end) state_in = ifp_pkg::ST_SIDH;
               end
               if (stat.rem_last) state_in = ifp_pkg::ST_CHK;
            end
         end
         ifp_pkg::ST_CHK: begin
            if (go) begin
               cmd.check = 1'b1;
               state_in = stat.sum_ok ? ifp_pkg::ST_EMIT : ifp_pkg::ST_HUNT;
            end
         end
         ifp_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.emit_step = 1'b1;
               if (stat.emit_last) state_in = ifp_pkg::ST_HUNT;
            end
         end
         default: state_in = ifp_pkg::ST_HUNT;
      endcase
   end
endmodule
`default_nettype wire

// ----- design/ifp_dp.sv -----
// byte assembly, value pickup, record storage and output register
`timescale 1ns / 1ps
`default_nettype none
module ifp_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       rx_byte,
   input  wire ifp_pkg::cmd_type cmd,
   input  wire logic             out_ready,
   output ifp_pkg::stat_type     stat,
   output logic                  out_free,
   output logic                  out_valid,
   output logic [3:0]            out_quantity,
   output logic [31:0]           out_value,
   output logic                  out_status,
   output logic [7:0]            out_mid,
   output logic                  out_last
);
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  mid_ff;
   logic [15:0] sid_ff;
   logic [7:0]  slen_ff, soff_ff;
   logic [31:0] asm_ff;
   logic [31:0] pend_ff [ifp_pkg::NumQ];
   logic [ifp_pkg::NumQ-1:0] pmask_ff;
   logic [31:0] rec_ff [ifp_pkg::NumQ];
   logic [3:0]  eidx_ff;
   logic        ov_ff;
   logic [3:0]  oq_ff;
   logic [31:0] oval_ff;
   logic        ost_ff, olast_ff;
   logic [7:0]  omid_ff;

   logic [31:0] asm_next;
   logic [15:0] grp, fmt;
   logic        wr_en;
   logic [3:0]  wr_q;
   logic [7:0]  soff_inc;

   assign sum_in = sum_ff + rx_byte;
   assign asm_next = {asm_ff[23:0], rx_byte};
   assign grp = sid_ff & ifp_pkg::GrpMask;
   assign fmt = sid_ff & ifp_pkg::FmtMask;
   assign soff_inc = soff_ff + 8'd1;
   assign rem_in = rem_ff - 16'd1;

   always_comb begin
      logic [3:0] base;
      logic [1:0] nw;
      logic       fl;
      base = '0;
      nw = '0;
      fl = 1'b0;
      wr_en = 1'b0;
      wr_q = '0;
      if (grp == ifp_pkg::GrpCount && fmt == ifp_pkg::FmtF2) begin
         wr_en = (soff_ff == 8'd1);
         wr_q = 4'd1;
      end else begin
         if (grp == ifp_pkg::GrpTemp && fmt == ifp_pkg::FmtF1) begin
            base = 4'd0; nw = 2'd1; fl = 1'b1;
         end else if (grp == ifp_pkg::GrpEuler && fmt == ifp_pkg::FmtF3) begin
            base = 4'd2; nw = 2'd3; fl = 1'b1;
         end else if (grp == ifp_pkg::GrpAccel && fmt == ifp_pkg::FmtF2) begin
            base = 4'd5; nw = 2'd3; fl = 1'b1;
         end else if (grp == ifp_pkg::GrpGyro && fmt == ifp_pkg::FmtF2) begin
            base = 4'd8; nw = 2'd3; fl = 1'b1;
         end else if (grp == ifp_pkg::GrpMag && fmt == ifp_pkg::FmtF2) begin
            base = 4'd11; nw = 2'd3; fl = 1'b1;
         end
         wr_en = fl && soff_ff[1:0] == 2'd3 && soff_ff[7:2] < {4'd0, nw};
         wr_q = base + {2'd0, soff_ff[3:2]};
      end
   end

   // a count word keeps only its low 16 bits
   logic [31:0] wr_val;
   assign wr_val = (wr_q == 4'd1) ? {16'd0, asm_next[15:0]} : asm_next;

   // upper length byte is cleared at frame start, so a short length sees zero there
   assign stat.len_zero = ({rem_ff[15:8], rx_byte} == 16'd0);
   assign stat.rem_last = (rem_in == 16'd0);
   assign stat.slen_zero = (rx_byte == 8'd0);
   assign stat.sub_end = (soff_inc == slen_ff);
   assign stat.sum_ok = (sum_in == 8'd0);
   assign stat.emit_last = (eidx_ff == 4'(ifp_pkg::NumQ - 1));

   always_ff @(posedge clock) begin
      if (cmd.start_frame) sum_ff <= ifp_pkg::BusByte;
      else if (cmd.add_sum) sum_ff <= sum_in;
      if (cmd.load_mid) mid_ff <= rx_byte;
      if (cmd.start_frame) rem_ff <= '0;
      else if (cmd.load_len) rem_ff <= {8'd0, rx_byte};
      else if (cmd.load_exth) rem_ff <= {rx_byte, 8'd0};
      else if (cmd.load_extl) rem_ff <= {rem_ff[15:8], rx_byte};
      else if (cmd.dec_len) rem_ff <= rem_in;
      if (cmd.load_sidh) sid_ff <= {rx_byte, 8'd0};
      if (cmd.load_sidl) sid_ff <= {sid_ff[15:8], rx_byte};
      if (cmd.load_slen) begin
         slen_ff <= rx_byte;
         soff_ff <= '0;
         asm_ff <= '0;
      end
      if (cmd.take_data) begin
         asm_ff <= asm_next;
         soff_ff <= soff_inc;
         if (wr_en) pend_ff[wr_q] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmask_ff <= '0;
         eidx_ff <= '0;
         ov_ff <= 1'b0;
         for (int i = 0; i < ifp_pkg::NumQ; i++) rec_ff[i] <= '0;
      end else begin
         if (cmd.start_frame || cmd.check) pmask_ff <= '0;
         else if (cmd.take_data && wr_en) pmask_ff[wr_q] <= 1'b1;
         if (cmd.check && stat.sum_ok) begin
            for (int i = 0; i < ifp_pkg::NumQ; i++)
               if (pmask_ff[i]) rec_ff[i] <= pend_ff[i];
         end
         if (out_ready) ov_ff <= 1'b0;
         if (cmd.check && !stat.sum_ok) begin
            ov_ff <= 1'b1;
            oq_ff <= '0;
            oval_ff <= '0;
            ost_ff <= 1'b1;
            omid_ff <= mid_ff;
            olast_ff <= 1'b1;
         end
         if (cmd.emit_step) begin
            ov_ff <= 1'b1;
            oq_ff <= eidx_ff;
            oval_ff <= rec_ff[eidx_ff];
            ost_ff <= 1'b0;
            omid_ff <= mid_ff;
            olast_ff <= stat.emit_last;
            eidx_ff <= stat.emit_last ? 4'd0 : eidx_ff + 4'd1;
         end
      end
   end

   assign out_free = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_quantity = oq_ff;
   assign out_value = oval_ff;
   assign out_status = ost_ff;
   assign out_mid = omid_ff;
   assign out_last = olast_ff;
endmodule
`default_nettype wire

// ----- design/imu_frame_parser_top.sv -----
// imu frame parser: byte stream in, record words out
// timing: an error word is registered and valid the cycle after the checksum byte; a good
//   record's first word goes out once the emit state loads the output register
// throughput: one byte per cycle while parsing, the checksum byte waiting for a free output
//   register; a good frame then emits 14 words, one per cycle while taken, with bytes held off until the last is loaded
// reset: synchronous active high; hunting for preamble, record cleared to zero
`timescale 1ns / 1ps
`default_nettype none
module imu_frame_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // quantity[3:0], value_bits[35:4], frame_mid[43:36]
   output logic             rsp_tuser,   // frame_status
   output logic             rsp_tlast    // last_of_run
);
   ifp_pkg::cmd_type  cmd;
   ifp_pkg::stat_type stat;
   logic out_free, in_ready;
   logic [3:0] q;
   logic [31:0] v;
   logic [7:0] m;

   ifp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .byte_valid(req_tvalid), .rx_byte(req_tdata),
      .out_free(out_free), .stat(stat), .cmd(cmd), .in_ready(in_ready)
   );

   ifp_dp u_dp (
      .clock(clock), .reset(reset), .rx_byte(req_tdata), .cmd(cmd),
      .out_ready(rsp_tready), .stat(stat), .out_free(out_free), .out_valid(rsp_tvalid),
      .out_quantity(q), .out_value(v), .out_status(rsp_tuser), .out_mid(m),
      .out_last(rsp_tlast)
   );

   // checksum byte is only taken once the output register can receive the result
   assign req_tready = in_ready;
   assign rsp_tdata = {4'd0, m, v, q};
endmodule
`default_nettype wire

// ----- design/ifp_checker.sv -----
// port-level assertions for the imu frame parser
`timescale 1ns / 1ps
`default_nettype none
`include "imu_frame_parser_top_macros.svh"
module ifp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);
   logic [3:0] rsp_q;
   logic       rec_word;
   logic       rec_mid;

   assign rsp_q = rsp_tdata[3:0];
   assign rec_word = rsp_tvalid && !rsp_tuser;
   // a record word other than the last one
   assign rec_mid = rec_word && !rsp_tlast;

   `IFP_ASSERT_IMPL(a_err_last, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_q == 4'd0, "bad error word")
   `IFP_ASSERT_IMPL(a_last_q, rec_word && rsp_tlast, rsp_q == 4'd13, "record ends off 13")
   `IFP_ASSERT_NEXT(a_seq, rec_mid && rsp_tready, rsp_tvalid && rsp_q == $past(rsp_q) + 4'd1, "out of order")
   `IFP_ASSERT_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   `IFP_ASSERT_IMPL(a_busy, rec_mid, !(req_tvalid && req_tready), "byte taken mid record")
endmodule
bind imu_frame_parser_top ifp_checker u_ifp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
`default_nettype wire

// ----- bench/imu_frame_parser_checker.sv -----
// checker for the imu frame parser: predicts record and error words from accepted bytes and compares
`timescale 1ns / 1ps
`default_nettype none
module imu_frame_parser_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               errors,
   output int               pending_words,
   output int               good_frames,
   output int               bad_frames
);
   typedef enum logic [3:0] {
      P_HUNT, P_BUS, P_MID, P_LEN, P_EXTH, P_EXTL,
      P_SIDH, P_SIDL, P_SLEN, P_DATA, P_CHK
   } phase_type;

   typedef struct packed {
      logic [3:0]  quantity;
      logic [31:0] value_bits;
      logic        frame_status;
      logic [7:0]  frame_mid;
      logic        last_of_run;
   } word_type;

   phase_type   phase;
   logic [15:0] remaining;
   logic [7:0]  sum;
   logic [7:0]  mid;
   logic [15:0] sub_id;
   logic [7:0]  sub_len;
   logic [7:0]  sub_off;
   logic [31:0] assembly;
   logic [31:0] pend_val [ifp_pkg::NumQ];
   logic [13:0] pend_mask;
   logic [31:0] record [ifp_pkg::NumQ];
   word_type    expected_words [$];

   initial pending_words = 0;

   task automatic store_pending(input int q, input logic [31:0] v);
      pend_val[q] = v;
      pend_mask[q] = 1'b1;
   endtask

   task automatic absorb_data(input logic [7:0] b);
      logic [15:0] grp;
      logic [15:0] fmt;
      int          base;
      int          nwords;
      grp = sub_id & ifp_pkg::GrpMask;
      fmt = sub_id & ifp_pkg::FmtMask;
      base = 0;
      nwords = 0;
      assembly = {assembly[23:0], b};
      if (grp == ifp_pkg::GrpCount && fmt == ifp_pkg::FmtF2) begin
         if (sub_off == 8'd1) store_pending(1, {16'h0, assembly[15:0]});
      end else begin
         if (grp == ifp_pkg::GrpTemp && fmt == ifp_pkg::FmtF1) begin
            base = 0; nwords = 1;
         end else if (grp == ifp_pkg::GrpEuler && fmt == ifp_pkg::FmtF3) begin
            base = 2; nwords = 3;
         end else if (grp == ifp_pkg::GrpAccel && fmt == ifp_pkg::FmtF2) begin
            base = 5; nwords = 3;
         end else if (grp == ifp_pkg::GrpGyro && fmt == ifp_pkg::FmtF2) begin
            base = 8; nwords = 3;
         end else if (grp == ifp_pkg::GrpMag && fmt == ifp_pkg::FmtF2) begin
            base = 11; nwords = 3;
         end
         if (nwords > 0 && sub_off[1:0] == 2'd3 && int'(sub_off >> 2) < nwords)
            store_pending(base + int'(sub_off >> 2), assembly);
      end
      sub_off = sub_off + 8'd1;
      if (sub_off == sub_len) phase = P_SIDH;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      word_type w;
      case (phase)
         P_HUNT: if (b == ifp_pkg::Preamble) phase = P_BUS;
         P_BUS: begin
            if (b == ifp_pkg::BusByte) begin
               sum = 8'hFF;
               pend_mask = '0;
               phase = P_MID;
            end else if (b != ifp_pkg::Preamble) begin
               phase = P_HUNT;
            end
         end
         P_MID: begin
            sum += b;
            mid = b;
            phase = P_LEN;
         end
         P_LEN: begin
            sum += b;
            if (b == ifp_pkg::ExtLen) phase = P_EXTH;
            else begin
               remaining = {8'h0, b};
               phase = (remaining == 0) ? P_CHK : P_SIDH;
            end
         end
         P_EXTH: begin
            sum += b;
            remaining = {b, 8'h0};
            phase = P_EXTL;
         end
         P_EXTL: begin
            sum += b;
            remaining[7:0] = b;
            phase = (remaining == 0) ? P_CHK : P_SIDH;
         end
         P_SIDH, P_SIDL, P_SLEN, P_DATA: begin
            sum += b;
            if (phase == P_SIDH) begin
               sub_id = {b, 8'h0};
               phase = P_SIDL;
            end else if (phase == P_SIDL) begin
               sub_id[7:0] = b;
               phase = P_SLEN;
            end else if (phase == P_SLEN) begin
               sub_len = b;
               sub_off = 0;
               assembly = 0;
               phase = (b == 0) ? P_SIDH : P_DATA;
            end else begin
               absorb_data(b);
            end
            remaining = remaining - 16'd1;
            if (remaining == 0) phase = P_CHK;
         end
         P_CHK: begin
            sum += b;
            phase = P_HUNT;
            if (sum == 0) begin
               for (int k = 0; k < ifp_pkg::NumQ; k++)
                  if (pend_mask[k]) record[k] = pend_val[k];
               for (int k = 0; k < ifp_pkg::NumQ; k++) begin
                  w.quantity = 4'(k);
                  w.value_bits = record[k];
                  w.frame_status = 1'b0;
                  w.frame_mid = mid;
                  w.last_of_run = (k == ifp_pkg::NumQ - 1);
                  expected_words.push_back(w);
               end
               good_frames++;
            end else begin
               w = '{4'd0, 32'd0, 1'b1, mid, 1'b1};
               expected_words.push_back(w);
               bad_frames++;
            end
            pend_mask = '0;
         end
         default: phase = P_HUNT;
      endcase
   endtask

   task automatic compare_word();
      word_type e;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected: %h", rsp_tdata);
         errors++;
         return;
      end
      e = expected_words.pop_front();
      if (rsp_tdata[3:0] != e.quantity) begin
         $error("quantity expected %0d actual %0d", e.quantity, rsp_tdata[3:0]);
         errors++;
      end
      if (rsp_tdata[35:4] != e.value_bits) begin
         $error("value_bits expected %h actual %h", e.value_bits, rsp_tdata[35:4]);
         errors++;
      end
      if (rsp_tdata[43:36] != e.frame_mid) begin
         $error("frame_mid expected %h actual %h", e.frame_mid, rsp_tdata[43:36]);
         errors++;
      end
      if (rsp_tuser != e.frame_status) begin
         $error("frame_status expected %0d actual %0d", e.frame_status, rsp_tuser);
         errors++;
      end
      if (rsp_tlast != e.last_of_run) begin
         $error("last_of_run expected %0d actual %0d", e.last_of_run, rsp_tlast);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = P_HUNT;
         remaining = 0;
         sum = 0;
         mid = 0;
         sub_id = 0;
         sub_len = 0;
         sub_off = 0;
         assembly = 0;
         pend_mask = 0;
         for (int k = 0; k < ifp_pkg::NumQ; k++) record[k] = 0;
         expected_words.delete();
         errors = 0;
         good_frames = 0;
         bad_frames = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) compare_word();
         if (req_tvalid && req_tready) predict_byte(req_tdata);
      end
      pending_words = expected_words.size();
   end
endmodule
`default_nettype wire

// ----- bench/imu_frame_parser_top_test.sv -----
// testbench top for the imu frame parser: byte stimulus, idling and verdict
`timescale 1ns / 1ps
`default_nettype none
module imu_frame_parser_top_test;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          errors;
   int          pending_words;
   int          good_frames;
   int          bad_frames;
   int          cycles = 0;
   int          bytes_sent = 0;
   logic        stim_done = 1'b0;
   logic [7:0]  frame_bytes [$];

   always #5 clock = ~clock;

   imu_frame_parser_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   imu_frame_parser_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .errors(errors), .pending_words(pending_words),
      .good_frames(good_frames), .bad_frames(bad_frames)
   );

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver stalls, with quiet stretches of none
   always @(negedge clock) begin
      if (cycles % 600 < 150) rsp_tready <= 1'b1;
      else rsp_tready <= (gap_length() == 0);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // one byte per handshake, gap before some bytes when idle is set
   task automatic send_byte(input logic [7:0] b, input logic idle);
      int g;
      g = idle ? gap_length() : 0;
      repeat (g) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic push_sub(input logic [15:0] id, input int len, input int nbytes);
      frame_bytes.push_back(id[15:8]);
      frame_bytes.push_back(id[7:0]);
      frame_bytes.push_back(8'(len));
      for (int i = 0; i < nbytes; i++) frame_bytes.push_back(8'($urandom));
   endtask

   // preamble, bus, mid, length, payload, checksum; corrupt flips one checksum bit
   task automatic send_frame(input logic [7:0] mid, input logic ext, input logic corrupt,
                             input logic idle);
      logic [7:0] s;
      int         n;
      n = frame_bytes.size();
      s = 8'hFF + mid;
      send_byte(ifp_pkg::Preamble, idle);
      send_byte(ifp_pkg::BusByte, idle);
      send_byte(mid, idle);
      if (ext || n >= 255) begin
         send_byte(ifp_pkg::ExtLen, idle);
         send_byte(8'(n >> 8), idle);
         send_byte(8'(n), idle);
         s += ifp_pkg::ExtLen + 8'(n >> 8) + 8'(n);
      end else begin
         send_byte(8'(n), idle);
         s += 8'(n);
      end
      foreach (frame_bytes[i]) begin
         s += frame_bytes[i];
         send_byte(frame_bytes[i], idle);
      end
      s = -s;
      if (corrupt) s ^= 8'(1 << $urandom_range(0, 7));
      send_byte(s, idle);
      frame_bytes.delete();
   endtask

   function automatic logic [15:0] known_id(input int kind);
      logic [15:0] low;
      low = 16'($urandom) & ~(ifp_pkg::GrpMask | ifp_pkg::FmtMask);
      case (kind)
         0: return ifp_pkg::GrpTemp | ifp_pkg::FmtF1 | low;
         1: return ifp_pkg::GrpCount | ifp_pkg::FmtF2 | low;
         2: return ifp_pkg::GrpEuler | ifp_pkg::FmtF3 | low;
         3: return ifp_pkg::GrpAccel | ifp_pkg::FmtF2 | low;
         4: return ifp_pkg::GrpGyro | ifp_pkg::FmtF2 | low;
         default: return ifp_pkg::GrpMag | ifp_pkg::FmtF2 | low;
      endcase
   endfunction

   task automatic build_random_payload();
      int subs;
      int kind;
      int full;
      int dl;
      subs = $urandom_range(0, 5);
      for (int i = 0; i < subs; i++) begin
         kind = $urandom_range(0, 6);
         if (kind == 6) begin
            dl = $urandom_range(0, 6);
            push_sub(16'($urandom), dl, dl);
         end else begin
            full = (kind == 0) ? 4 : (kind == 1) ? 2 : 12;
            dl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, full + 3) : full;
            push_sub(known_id(kind), dl, dl);
         end
      end
      // sometimes cut the last sub-packet short by the payload end
      if (frame_bytes.size() > 3 && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) void'(frame_bytes.pop_back());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: sync cases, zero length, every group, short and cut sub-packets
      send_byte(8'h00, 1'b0);
      send_byte(ifp_pkg::Preamble, 1'b0);
      send_byte(ifp_pkg::Preamble, 1'b0);
      send_byte(8'h12, 1'b0);
      send_frame(8'h00, 1'b0, 1'b0, 1'b0);
      send_frame(8'hFF, 1'b1, 1'b0, 1'b0);
      for (int k = 0; k < 6; k++) push_sub(known_id(k), (k == 0) ? 4 : (k == 1) ? 2 : 12,
                                           (k == 0) ? 4 : (k == 1) ? 2 : 12);
      push_sub(16'hFFFF, 0, 0);
      push_sub(16'h3456, 2, 2);
      send_frame(8'h36, 1'b0, 1'b0, 1'b0);
      push_sub(known_id(3), 7, 7);
      push_sub(known_id(0), 6, 6);
      push_sub(known_id(5), 12, 9);
      send_frame(8'hA5, 1'b0, 1'b0, 1'b0);
      push_sub(known_id(4), 12, 12);
      send_frame(8'h5A, 1'b0, 1'b1, 1'b0);
      // drain every expected word before the random part
      while (pending_words != 0) @(posedge clock);

      // random: mostly well-formed frames, some bad checksums and line noise
      while (bytes_sent < 400) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b1);
         end else begin
            build_random_payload();
            send_frame(8'($urandom), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 5) == 0, 1'b1);
         end
         if ($urandom_range(0, 19) == 0) begin
            while (pending_words != 0) @(posedge clock);
         end
      end
      stim_done <= 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending_words != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d bytes; %0d good frames and %0d checksum errors seen",
               bytes_sent, good_frames, bad_frames);
      if (errors == 0 && pending_words == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/ifp_pkg.sv
design/ifp_ctrl.sv
design/ifp_dp.sv
design/imu_frame_parser_top.sv
design/ifp_checker.sv
bench/imu_frame_parser_checker.sv
bench/imu_frame_parser_top_test.sv
